/* hdl/pwpm_pkg.sv */
// Shared constants, codes and control types of the pulse width and period meter.
package pwpm_pkg;

   localparam int SAMPLE_W            = 8;
   localparam int FIELD_W             = 12;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 12;
   localparam int POSITION_LIMIT_DEF  = 4096;

   localparam logic [SAMPLE_W:0]    BAND            = 9'd5;
   localparam logic [FIELD_W-1:0]   FIELD_MAX       = 12'd4095;
   localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET = 8'd128;
   localparam logic [FIELD_W-1:0]   FIRST_POS_RESET = 12'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD      = 2'd0,
      CSR_FIRST_POSITION = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_FALL = 2'd2
   } edge_kind_type;

   // controller to datapath
   typedef struct packed {
      logic sample_en;    // a sample beat is taken this cycle
      logic div_step;     // one quotient bit
      logic result_load;  // move finished result into output register
   } cmd_type;

endpackage

/* hdl/pwpm_ifs.sv */
// Handshake channel interfaces for samples, results and register writes.
interface pwpm_req_bus
   import pwpm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface pwpm_rsp_bus
   import pwpm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] high_width;
   logic [FIELD_W-1:0] low_width;
   logic [FIELD_W-1:0] period;

   modport source (output valid, high_width, low_width, period, input ready);
   modport sink   (input valid, high_width, low_width, period, output ready);
endinterface

interface pwpm_csr_bus
   import pwpm_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/pulse_width_period_meter.sv */
// Pulse width and period meter: one scope trace in, one measurement beat out.
// Throughput: one sample beat per cycle inside a trace; after the last sample
//   req ready stays low through the PW divider steps (PW = clog2(POSITION_LIMIT), 12 by default)
//   and the handoff state, and longer while an older result waits.
// Result: after the last sample beat the controller runs ST_DIVIDE, then ST_DONE registers the result beat.
// Reset: threshold 128, first position 20, trace state cleared, no result held.
module pulse_width_period_meter
   import pwpm_pkg::*;
#(
   parameter int POSITION_LIMIT = POSITION_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pwpm_req_bus.sink   req_bus,
   pwpm_rsp_bus.source rsp_bus,
   pwpm_csr_bus.sink   csr_bus
);

   cmd_type cmd;
   logic    csr_we;

   // register writes are always taken; software is to write only while idle, the block does not enforce it
   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid && csr_bus.ready;

   // controller: streams samples, runs the divide, hands off the result beat
   pwpm_ctrl #(
      .POSITION_LIMIT (POSITION_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_sample),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // datapath: hysteresis level, edge positions, divider, output register
   pwpm_datapath #(
      .POSITION_LIMIT (POSITION_LIMIT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (req_bus.sample),
      .last_sample (req_bus.last_sample),
      .csr_we      (csr_we),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .high_width  (rsp_bus.high_width),
      .low_width   (rsp_bus.low_width),
      .period      (rsp_bus.period)
   );

endmodule

/* hdl/pwpm_ctrl.sv */
// Controller: sample streaming, period divide sequencing and result handoff.
module pwpm_ctrl
   import pwpm_pkg::*;
#(
   parameter int POSITION_LIMIT = POSITION_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam int PW    = $clog2(POSITION_LIMIT);
   localparam int CNT_W = $clog2(PW);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cmd.sample_en   = 1'b0;
      cmd.div_step    = 1'b0;
      cmd.result_load = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            cmd.sample_en = accept;
            if (accept && req_last) begin
               state_in = ST_DIVIDE;
               cnt_in   = '0;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/pwpm_datapath.sv */
// Datapath: comparator, edge tracking, serial divider and result registers.
module pwpm_datapath
   import pwpm_pkg::*;
#(
   parameter int POSITION_LIMIT = POSITION_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [SAMPLE_W-1:0]   sample,
   input  logic                  last_sample,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [FIELD_W-1:0]    high_width,
   output logic [FIELD_W-1:0]    low_width,
   output logic [FIELD_W-1:0]    period
);

   localparam int PW = $clog2(POSITION_LIMIT);
   localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;
   localparam logic [PW-1:0] POS_MAX = PW'(POSITION_LIMIT - 1);

   // config
   logic [SAMPLE_W-1:0] threshold_ff;
   logic [FIELD_W-1:0]  first_pos_ff;

   // per-trace state
   logic                level_ff, level_in;
   logic                seen_first_ff, seen_first_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       rise_one_ff, rise_one_in;
   logic [PW-1:0]       rise_two_ff, rise_two_in;
   logic [PW-1:0]       fall_one_ff, fall_one_in;
   logic [PW-1:0]       fall_two_ff, fall_two_in;
   edge_kind_type       edge_kind_ff, edge_kind_in;
   logic [PW-1:0]       span_begin_ff, span_begin_in;
   logic [PW-1:0]       span_end_ff, span_end_in;
   logic [FIELD_W-1:0]  cycles_ff, cycles_in;

   // end-of-trace hold and divider
   logic [FIELD_W-1:0]  hw_hold_ff, hw_hold_in;
   logic [FIELD_W-1:0]  lw_hold_ff, lw_hold_in;
   logic [PW-1:0]       quo_ff, quo_in;
   logic [FIELD_W:0]    rem_ff, rem_in;
   logic [FIELD_W-1:0]  div_ff, div_in;

   // output register
   logic [FIELD_W-1:0]  high_width_ff, low_width_ff, period_ff;

   logic [SAMPLE_W:0]   s9, th9;
   logic                above, below, is_edge;
   edge_kind_type       kind;
   logic [PW-1:0]       hw_raw, lw_raw, span;
   logic                per_ok;
   logic [FIELD_W:0]    rem_sh;

   assign s9    = {1'b0, sample};
   assign th9   = {1'b0, threshold_ff};
   assign above = s9 > (th9 + BAND);
   assign below = (s9 + BAND) < th9;

   // sample step
   always_comb begin
      pos_in        = pos_ff;
      level_in      = level_ff;
      seen_first_in = seen_first_ff;
      rise_one_in   = rise_one_ff;
      rise_two_in   = rise_two_ff;
      fall_one_in   = fall_one_ff;
      fall_two_in   = fall_two_ff;
      edge_kind_in  = edge_kind_ff;
      span_begin_in = span_begin_ff;
      span_end_in   = span_end_ff;
      cycles_in     = cycles_ff;
      kind          = level_ff ? EDGE_FALL : EDGE_RISE;
      is_edge       = 1'b0;

      if (!seen_first_ff) begin
         pos_in = (CW'(first_pos_ff) > CW'(POS_MAX)) ? POS_MAX : PW'(first_pos_ff);
      end else if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end

      if (above) begin
         level_in = 1'b1;
      end else if (below) begin
         level_in = 1'b0;
      end

      is_edge = seen_first_ff && (level_in != level_ff);
      if (is_edge) begin
         if (!level_in) begin
            if (rise_two_ff == '0 && rise_one_ff != '0) rise_two_in = pos_in;
            if (fall_one_ff == '0) fall_one_in = pos_in;
         end else begin
            if (fall_two_ff == '0 && fall_one_ff != '0) fall_two_in = pos_in;
            if (rise_one_ff == '0) rise_one_in = pos_in;
         end
         if (edge_kind_ff == EDGE_NONE) begin
            edge_kind_in  = kind;
            span_begin_in = pos_in;
         end else if (edge_kind_ff == kind) begin
            if (cycles_ff != FIELD_MAX) cycles_in = cycles_ff + 1'b1;
            span_end_in = pos_in;
         end
      end
      seen_first_in = 1'b1;
   end

   // end-of-trace figures from the updated state
   always_comb begin
      hw_raw = (rise_two_in != '0 && rise_one_in != '0) ? rise_two_in - rise_one_in : '0;
      lw_raw = (fall_two_in != '0 && fall_one_in != '0) ? fall_two_in - fall_one_in : '0;
      span   = span_end_in - span_begin_in;
      per_ok = (cycles_in != '0) && (span_end_in != '0) && (span_end_in >= span_begin_in);
      hw_hold_in = (CW'(hw_raw) > CW'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(hw_raw);
      lw_hold_in = (CW'(lw_raw) > CW'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(lw_raw);
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_sh = {rem_ff[FIELD_W-1:0], quo_ff[PW-1]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (cmd.sample_en && last_sample) begin
         quo_in = per_ok ? span : '0;
         rem_in = '0;
         div_in = per_ok ? cycles_in : FIELD_W'(1);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[PW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         first_pos_ff <= FIRST_POS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD:      threshold_ff <= csr_data[SAMPLE_W-1:0];
            CSR_FIRST_POSITION: first_pos_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.sample_en && last_sample)) begin
         level_ff      <= 1'b0;
         seen_first_ff <= 1'b0;
         pos_ff        <= '0;
         rise_one_ff   <= '0;
         rise_two_ff   <= '0;
         fall_one_ff   <= '0;
         fall_two_ff   <= '0;
         edge_kind_ff  <= EDGE_NONE;
         span_begin_ff <= '0;
         span_end_ff   <= '0;
         cycles_ff     <= '0;
      end else if (cmd.sample_en) begin
         level_ff      <= level_in;
         seen_first_ff <= seen_first_in;
         pos_ff        <= pos_in;
         rise_one_ff   <= rise_one_in;
         rise_two_ff   <= rise_two_in;
         fall_one_ff   <= fall_one_in;
         fall_two_ff   <= fall_two_in;
         edge_kind_ff  <= edge_kind_in;
         span_begin_ff <= span_begin_in;
         span_end_ff   <= span_end_in;
         cycles_ff     <= cycles_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_en && last_sample) begin
         hw_hold_ff <= hw_hold_in;
         lw_hold_ff <= lw_hold_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (cmd.result_load) begin
         high_width_ff <= hw_hold_ff;
         low_width_ff  <= lw_hold_ff;
         period_ff     <= (CW'(quo_ff) > CW'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(quo_ff);
      end
   end

   assign high_width = high_width_ff;
   assign low_width  = low_width_ff;
   assign period     = period_ff;

endmodule
